[rtl/observation_confirm_aging_table_unit_macros.svh]
// assertion macros for the observation confirm aging table unit
`ifndef OBSERVATION_CONFIRM_AGING_TABLE_UNIT_MACROS_SVH
`define OBSERVATION_CONFIRM_AGING_TABLE_UNIT_MACROS_SVH

// condition in this cycle implies consequence in the same cycle
`define OCAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ocat assertion failed");

// condition in this cycle implies consequence in the next cycle
`define OCAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ocat assertion failed");

`endif

[rtl/ocat_pkg.sv]
// package: constants, codes and item types of the observation confirm aging table
package ocat_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int KEY_BITS    = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int KEY_FIELD_W = 16;
  localparam int KEY_W       = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int CNT_W       = 16;
  localparam int TIME_W      = 32;

  localparam logic [CNT_W-1:0]  THRESHOLD_RESET = 16'd30;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET   = 32'd60000;
  localparam logic [CNT_W-1:0]  CNT_MAX         = '1;

  localparam logic [2:0] CMD_OBSERVE = 3'd0;
  localparam logic [2:0] CMD_FORCE   = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_SWEEP   = 3'd3;
  localparam logic [2:0] CMD_LOOKUP  = 3'd4;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_BLOCK   = 2'd1;
  localparam logic [1:0] ACT_REMOVED = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_SKIPPED   = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TIMEOUT   = 1'b1;

  typedef struct packed {
    logic [2:0]             command;
    logic [KEY_FIELD_W-1:0] item_key;
    logic                   already_blocked;
    logic                   zone_item;
    logic                   intersection_item;
    logic [TIME_W-1:0]      now_ms;
  } item_t;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] result_key;
    logic [1:0]             action;
    logic                   found;
    logic                   is_published;
    logic [CNT_W-1:0]       hit_count;
    logic [1:0]             status;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] seen_time;
    logic              published;
  } slot_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_idx;
    logic             full;
    logic [IDX_W-1:0] free_idx;
  } cam_match_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } cam_update_t;

endpackage

[rtl/ocat_ram.sv]
// generic single write port ram with registered read
module ocat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ocat_cam.sv]
// key store with valid bits, key match and free slot search
module ocat_cam (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ocat_pkg::KEY_W-1:0] query_key,
  output ocat_pkg::cam_match_t      match,
  input  ocat_pkg::cam_update_t     upd,
  input  logic [ocat_pkg::IDX_W-1:0] rd_idx,
  output logic                      rd_valid,
  output logic [ocat_pkg::KEY_W-1:0] rd_key
);
  import ocat_pkg::*;

  logic [TABLE_DEPTH-1:0] valid;
  logic [KEY_W-1:0]       keys [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit;

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit[i] = valid[i] && (keys[i] == query_key);
    end
  end

  // lowest index wins
  always_comb begin
    match.found     = |hit;
    match.full      = &valid;
    match.match_idx = '0;
    match.free_idx  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match.match_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        match.free_idx = IDX_W'(i);
      end
    end
  end

  assign rd_valid = valid[rd_idx];
  assign rd_key   = keys[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (upd.set) begin
      valid[upd.idx] <= 1'b1;
    end else if (upd.clr) begin
      valid[upd.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set) begin
      keys[upd.idx] <= upd.key;
    end
  end

endmodule

[rtl/observation_confirm_aging_table_unit.sv]
// top level of the observation confirm aging table unit
//
//  channel   signals                               handshake
//  -------   -----------------------------------   -------------------------------
//  command   start, busy, item                     taken when start and not busy
//  result    done, result                          one cycle pulse, no back pressure
//  config    psel penable pwrite paddr pwdata      write on access phase, pready high
//            prdata pready
//
// observe, force, remove, lookup and unknown codes do the key match and slot ram read in the
// accept cycle, then the read-modify-write in the exec state, which registers the result.
// sweep does one slot ram read per cycle over every slot, then passes the end state; each sweep
// result is held until the next hit slot or the end cycle, so only the final one has last.
// synchronous reset clears the valid bits and the sequencer and sets both registers to their defaults.
// busy is high while a command is in progress; results are never held off.
`include "observation_confirm_aging_table_unit_macros.svh"

module observation_confirm_aging_table_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ocat_pkg::item_t   item,
  output logic              done,
  output ocat_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ocat_pkg::*;

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_EXEC      = 2'd1;
  localparam logic [1:0] ST_SWEEP     = 2'd2;
  localparam logic [1:0] ST_SWEEP_END = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  threshold;
  logic [TIME_W-1:0] timeout;

  logic              accept;
  logic              cfg_write;

  // latched item and match
  logic [2:0]        cmd_q;
  logic [KEY_W-1:0]  key_q;
  logic              skip_q;
  logic [TIME_W-1:0] now_q;
  cam_match_t        match_q;
  logic [IDX_W-1:0]  scan_idx;

  cam_match_t        match;
  cam_update_t       upd;
  logic              cam_rd_valid;
  logic [KEY_W-1:0]  cam_rd_key;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  slot_t             rd;

  result_t           exec_res;
  result_t           sweep_res;
  logic              sweep_hit;
  logic              sweep_evict;
  result_t           pend;
  logic              pend_valid;
  result_t           pend_early;
  result_t           sweep_none;

  logic [CNT_W-1:0]  base_cnt;
  logic              base_pub;
  logic [CNT_W-1:0]  new_cnt;
  logic              pub_now;
  logic [TIME_W-1:0] elapsed;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // byte offset bits are ignored
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout : {16'd0, threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      timeout   <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_THRESHOLD) begin
        threshold <= pwdata[CNT_W-1:0];
      end else begin
        timeout <= pwdata;
      end
    end
  end

  ocat_cam u_cam (
    .clk       (clk),
    .rst       (rst),
    .query_key (item.item_key[KEY_W-1:0]),
    .match     (match),
    .upd       (upd),
    .rd_idx    (scan_idx),
    .rd_valid  (cam_rd_valid),
    .rd_key    (cam_rd_key)
  );

  ocat_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  always_comb begin
    if (state == ST_SWEEP) begin
      ram_raddr = IDX_W'(scan_idx + 1'b1);
    end else if (item.command == CMD_SWEEP) begin
      ram_raddr = '0;
    end else if (match.found) begin
      ram_raddr = match.match_idx;
    end else begin
      ram_raddr = match.free_idx;
    end
  end

  // single command read-modify-write and sweep eviction clear
  always_comb begin
    base_cnt = match_q.found ? rd.count : '0;
    base_pub = match_q.found && rd.published;
    if (cmd_q == CMD_OBSERVE) begin
      new_cnt = (base_cnt != CNT_MAX) ? CNT_W'(base_cnt + 1'b1) : base_cnt;
    end else begin
      new_cnt = (threshold != CNT_MAX) ? CNT_W'(threshold + 1'b1) : CNT_MAX;
    end
    pub_now = (new_cnt > threshold);

    exec_res            = '0;
    exec_res.result_key = KEY_FIELD_W'(key_q);
    exec_res.last       = 1'b1;
    ram_we              = 1'b0;
    ram_waddr           = match_q.found ? match_q.match_idx : match_q.free_idx;
    ram_wdata.count     = new_cnt;
    ram_wdata.seen_time = now_q;
    ram_wdata.published = base_pub || pub_now;
    upd                 = '0;
    upd.idx             = ram_waddr;
    upd.key             = key_q;

    unique case (cmd_q)
      CMD_OBSERVE, CMD_FORCE: begin
        if (skip_q) begin
          exec_res.status       = STS_SKIPPED;
          exec_res.found        = match_q.found;
          exec_res.is_published = base_pub;
          exec_res.hit_count    = base_cnt;
        end else if (!match_q.found && match_q.full) begin
          exec_res.status = STS_FULL;
        end else begin
          exec_res.found        = 1'b1;
          exec_res.is_published = base_pub || pub_now;
          exec_res.hit_count    = new_cnt;
          exec_res.action       = pub_now ? ACT_BLOCK : ACT_NONE;
          ram_we                = (state == ST_EXEC);
          upd.set               = (state == ST_EXEC) && !match_q.found;
        end
      end
      CMD_REMOVE: begin
        if (match_q.found) begin
          exec_res.action = ACT_REMOVED;
          exec_res.found  = 1'b1;
          upd.clr         = (state == ST_EXEC);
        end else begin
          exec_res.status = STS_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        if (match_q.found) begin
          exec_res.found        = 1'b1;
          exec_res.is_published = rd.published;
          exec_res.hit_count    = rd.count;
        end else begin
          exec_res.status = STS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase

    if (state == ST_SWEEP && sweep_evict) begin
      upd.clr = 1'b1;
      upd.idx = scan_idx;
    end
  end

  // sweep slot evaluation
  always_comb begin
    elapsed     = TIME_W'(now_q - rd.seen_time);
    sweep_evict = cam_rd_valid && (elapsed > timeout);
    sweep_hit   = sweep_evict || (cam_rd_valid && rd.published);
    sweep_res            = '0;
    sweep_res.result_key = KEY_FIELD_W'(cam_rd_key);
    sweep_res.found      = 1'b1;
    sweep_res.status     = STS_OK;
    sweep_res.last       = 1'b1;
    if (sweep_evict) begin
      sweep_res.action = ACT_REMOVED;
    end else begin
      sweep_res.action       = ACT_BLOCK;
      sweep_res.is_published = 1'b1;
      sweep_res.hit_count    = rd.count;
    end
    pend_early      = pend;
    pend_early.last = 1'b0;
    sweep_none      = '0;
    sweep_none.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= item.command;
      key_q   <= item.item_key[KEY_W-1:0];
      skip_q  <= item.already_blocked || item.zone_item ||
                 (item.command == CMD_OBSERVE && item.intersection_item);
      now_q   <= item.now_ms;
      match_q <= match;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      pend_valid <= 1'b0;
      scan_idx   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          scan_idx <= '0;
          if (accept) begin
            state <= (item.command == CMD_SWEEP) ? ST_SWEEP : ST_EXEC;
          end
        end
        ST_EXEC: begin
          done   <= 1'b1;
          result <= exec_res;
          state  <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (sweep_hit) begin
            if (pend_valid) begin
              done   <= 1'b1;
              result <= pend_early;
            end
            pend       <= sweep_res;
            pend_valid <= 1'b1;
          end
          scan_idx <= IDX_W'(scan_idx + 1'b1);
          if (scan_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= ST_SWEEP_END;
          end
        end
        ST_SWEEP_END: begin
          done <= 1'b1;
          if (pend_valid) begin
            result <= pend;
          end else begin
            result <= sweep_none;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `OCAT_ASSERT_NEXT(a_exec_gives_result, state == ST_EXEC, done && result.last)
  `OCAT_ASSERT_NEXT(a_sweep_ends_with_last, state == ST_SWEEP_END, done && result.last)
  `OCAT_ASSERT_NOW(a_early_result_only_in_sweep, done && !result.last, state == ST_SWEEP || state == ST_SWEEP_END)
  `OCAT_ASSERT_NEXT(a_accept_sets_busy, accept, busy)

endmodule
